// ===== rtl/cinf_pkg.sv =====
// cinf_pkg: shared constants, types and codes for the obstacle inflation block
// used by cinf_front, cinf_decay, cinf_back and costmap_obstacle_inflation
`timescale 1ns / 1ps
package cinf_pkg;

    localparam int GRID_SIZE = 256;
    localparam int GRID_W    = $clog2(GRID_SIZE);
    localparam int ADDR_W    = 2 * GRID_W;

    localparam int RAD_W  = 5;
    localparam int COST_W = 7;
    localparam int X_W    = 10;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [COST_W-1:0] OBSTACLE_COST = COST_W'(100);
    localparam logic [RAD_W-1:0]  RADIUS_RESET  = RAD_W'(16);
    localparam logic [COST_W-1:0] MAX_COST_RESET = COST_W'(100);

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_MARK    = 2'd1,
        ACT_INFLATE = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef enum logic {
        CFG_RADIUS   = 1'b0,
        CFG_MAX_COST = 1'b1
    } cfg_index_t;

    typedef struct packed {
        action_t           action;
        logic [ADDR_W-1:0] addr;
        logic              in_grid;
    } cinf_cmd_t;

endpackage

// ===== rtl/cinf_front.sv =====
// cinf_front: accepts input transactions, checks grid bounds, forms cell address
// and holds commands in a two-entry queue; depends on cinf_pkg
`timescale 1ns / 1ps
module cinf_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cinf_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              init_busy,
    output cinf_pkg::cinf_cmd_t               cmd,
    output logic                              cmd_valid,
    input  logic                              cmd_pop
);
    import cinf_pkg::*;

    cinf_cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic signed [X_W-1:0] x_s, y_s;
    cinf_cmd_t  in_cmd;

    assign x_s = s_tdata[11:2];
    assign y_s = s_tdata[21:12];

    always_comb begin
        in_cmd.action  = action_t'(s_tdata[1:0]);
        in_cmd.in_grid = (int'(x_s) >= 0) && (int'(x_s) < GRID_SIZE) &&
                         (int'(y_s) >= 0) && (int'(y_s) < GRID_SIZE);
        in_cmd.addr    = {x_s[GRID_W-1:0], y_s[GRID_W-1:0]};
    end

    assign s_tready  = (cnt_reg != 2'd2) && !init_busy;
    assign push      = s_tvalid && s_tready;
    assign cmd       = q_reg[0];
    assign cmd_valid = (cnt_reg != 2'd0);

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !cmd_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && cmd_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            q_reg[0] <= q_reg[1];
            if (push && cnt_reg == 2'd1) begin
                q_reg[0] <= in_cmd;
            end else if (push) begin
                q_reg[1] <= in_cmd;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                q_reg[0] <= in_cmd;
            end else begin
                q_reg[1] <= in_cmd;
            end
        end
    end
endmodule

// ===== rtl/cinf_decay.sv =====
// cinf_decay: computes one decay table entry m*(span-q)/span
// with a bit-serial square root and restoring divide; depends on cinf_pkg
`timescale 1ns / 1ps
module cinf_decay (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cinf_pkg::RAD_W-1:0]    ax,
    input  logic [cinf_pkg::RAD_W-1:0]    ay,
    input  logic [cinf_pkg::RAD_W-1:0]    radius,
    input  logic [cinf_pkg::COST_W-1:0]   max_cost,
    output logic                          done,
    output logic [cinf_pkg::COST_W-1:0]   cost
);
    import cinf_pkg::*;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_SQRT = 4'b0010,
        D_MUL  = 4'b0100,
        D_DIV  = 4'b1000
    } dstate_t;

    dstate_t      state_reg;
    logic [27:0]  v_reg;
    logic [17:0]  rem_reg;
    logic [13:0]  root_reg;
    logic [3:0]   cnt_reg;
    logic         over_reg;
    logic [19:0]  num_reg;
    logic [COST_W-1:0] quot_reg;
    logic         done_reg;

    logic [10:0]  s_sum, r_sq;
    logic [17:0]  rem_sh, trial;
    logic [12:0]  span;
    logic [13:0]  q_clip, q_diff;
    logic [19:0]  dv;

    assign s_sum  = ({6'd0, ax} * {6'd0, ax}) + ({6'd0, ay} * {6'd0, ay});
    assign r_sq   = {6'd0, radius} * {6'd0, radius};
    assign rem_sh = {rem_reg[15:0], v_reg[27:26]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign span   = {radius, 8'd0};
    assign q_clip = (root_reg > {1'b0, span}) ? {1'b0, span} : root_reg;
    assign q_diff = {1'b0, span} - q_clip;
    assign dv     = 20'({7'd0, span} << cnt_reg[2:0]);

    assign done = done_reg;
    assign cost = over_reg ? '0 : quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        state_reg <= D_SQRT;
                    end
                end
                D_SQRT: begin
                    if (cnt_reg == 4'd0) begin
                        state_reg <= D_MUL;
                    end
                end
                D_MUL: begin
                    state_reg <= D_DIV;
                end
                D_DIV: begin
                    if (cnt_reg == 4'd0) begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            D_IDLE: begin
                v_reg    <= {1'b0, s_sum, 16'd0};
                over_reg <= s_sum > r_sq;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 4'd13;
            end
            D_SQRT: begin
                // one root bit per cycle
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[12:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[12:0], 1'b0};
                end
                v_reg   <= {v_reg[25:0], 2'b00};
                cnt_reg <= cnt_reg - 4'd1;
            end
            D_MUL: begin
                num_reg  <= {6'd0, q_diff} * {13'd0, max_cost};
                quot_reg <= '0;
                cnt_reg  <= 4'd6;
            end
            D_DIV: begin
                if (num_reg >= dv) begin
                    num_reg  <= num_reg - dv;
                    quot_reg <= quot_reg | COST_W'(7'd1 << cnt_reg[2:0]);
                end
                cnt_reg <= cnt_reg - 4'd1;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/cinf_back.sv =====
// cinf_back: cost grid memory, clear sweep, decay table build and inflation walk,
// plus the result register; depends on cinf_pkg and cinf_decay
`timescale 1ns / 1ps
module cinf_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cinf_pkg::cinf_cmd_t               cmd,
    input  logic                              cmd_valid,
    output logic                              cmd_pop,
    output logic                              init_busy,
    input  logic [cinf_pkg::RAD_W-1:0]        radius,
    input  logic [cinf_pkg::COST_W-1:0]       max_cost,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cinf_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import cinf_pkg::*;

    typedef enum logic [9:0] {
        S_INIT     = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_CLEAR    = 10'b0000000100,
        S_READ     = 10'b0000001000,
        S_TBL      = 10'b0000010000,
        S_TBL_WAIT = 10'b0000100000,
        S_SCAN     = 10'b0001000000,
        S_SCAN_CHK = 10'b0010000000,
        S_NB_RD    = 10'b0100000000,
        S_NB_WR    = 10'b1000000000
    } state_t;

    localparam logic signed [GRID_W+1:0] GRID_LIM = (GRID_W+2)'(GRID_SIZE);
    localparam logic [GRID_W-1:0]        CELL_LAST = GRID_W'(GRID_SIZE - 1);

    logic [COST_W-1:0] grid_mem [2**ADDR_W];
    logic [COST_W-1:0] tbl_mem  [2**(2*RAD_W)];

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [GRID_W-1:0] wx_reg, wx_next, wy_reg, wy_next;
    logic signed [RAD_W:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [RAD_W-1:0]  tax_reg, tax_next, tay_reg, tay_next;
    logic              out_valid_reg, out_valid_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    logic              out_rng_reg, out_rng_next;

    logic [COST_W-1:0] rd_data_reg, tbl_data_reg;
    logic              we, tbl_we, dec_start, dec_done;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [COST_W-1:0] wdata, dec_cost;

    logic signed [RAD_W:0] r_pos, r_neg;
    logic signed [GRID_W+1:0] nx, ny;
    logic              nb_ok, nb_last, cell_last;
    logic [RAD_W-1:0]  adx, ady;

    cinf_decay u_decay (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dec_start),
        .ax       (tax_reg),
        .ay       (tay_reg),
        .radius   (radius),
        .max_cost (max_cost),
        .done     (dec_done),
        .cost     (dec_cost)
    );

    assign r_pos = $signed({1'b0, radius});
    assign r_neg = -r_pos;
    assign nx = $signed({2'b00, wx_reg}) + (GRID_W+2)'(dx_reg);
    assign ny = $signed({2'b00, wy_reg}) + (GRID_W+2)'(dy_reg);
    assign nb_ok = !nx[GRID_W+1] && (nx < GRID_LIM) && !ny[GRID_W+1] && (ny < GRID_LIM);
    assign nb_last = (dx_reg == r_pos) && (dy_reg == r_pos);
    assign cell_last = (wx_reg == CELL_LAST) && (wy_reg == CELL_LAST);
    assign adx = dx_reg[RAD_W] ? RAD_W'(-dx_reg) : dx_reg[RAD_W-1:0];
    assign ady = dy_reg[RAD_W] ? RAD_W'(-dy_reg) : dy_reg[RAD_W-1:0];

    assign init_busy = (state_reg == S_INIT);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_rng_reg, out_cost_reg};

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        tax_next       = tax_reg;
        tay_next       = tay_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cost_next  = out_cost_reg;
        out_rng_next   = out_rng_reg;
        cmd_pop        = 1'b0;
        we             = 1'b0;
        waddr          = clr_reg;
        wdata          = '0;
        raddr          = cmd.addr;
        tbl_we         = 1'b0;
        dec_start      = 1'b0;

        unique case (state_reg)
            S_INIT, S_CLEAR: begin
                we       = 1'b1;
                clr_next = clr_reg + ADDR_W'(1);
                if (&clr_reg) begin
                    state_next = S_IDLE;
                    if (state_reg == S_CLEAR) begin
                        out_valid_next = 1'b1;
                        out_cost_next  = '0;
                        out_rng_next   = 1'b0;
                    end
                end
            end
            S_IDLE: begin
                if (cmd_valid && !out_valid_next) begin
                    cmd_pop       = 1'b1;
                    out_cost_next = '0;
                    out_rng_next  = 1'b0;
                    unique case (cmd.action)
                        ACT_CLEAR: begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        ACT_MARK: begin
                            we             = cmd.in_grid;
                            waddr          = cmd.addr;
                            wdata          = OBSTACLE_COST;
                            out_rng_next   = cmd.in_grid;
                            out_valid_next = 1'b1;
                        end
                        ACT_INFLATE: begin
                            if (radius == '0) begin
                                out_valid_next = 1'b1;
                            end else begin
                                tax_next   = '0;
                                tay_next   = '0;
                                state_next = S_TBL;
                            end
                        end
                        ACT_READ: begin
                            if (cmd.in_grid) begin
                                out_rng_next = 1'b1;
                                state_next   = S_READ;
                            end else begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                out_cost_next  = rd_data_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_TBL: begin
                dec_start  = 1'b1;
                state_next = S_TBL_WAIT;
            end
            S_TBL_WAIT: begin
                if (dec_done) begin
                    tbl_we = 1'b1;
                    if (tay_reg == radius) begin
                        tay_next = '0;
                        if (tax_reg == radius) begin
                            wx_next    = '0;
                            wy_next    = '0;
                            state_next = S_SCAN;
                        end else begin
                            tax_next   = tax_reg + RAD_W'(1);
                            state_next = S_TBL;
                        end
                    end else begin
                        tay_next   = tay_reg + RAD_W'(1);
                        state_next = S_TBL;
                    end
                end
            end
            S_SCAN: begin
                raddr      = {wx_reg, wy_reg};
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (rd_data_reg == OBSTACLE_COST) begin
                    dx_next    = r_neg;
                    dy_next    = r_neg;
                    state_next = S_NB_RD;
                end else if (cell_last) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end else begin
                    state_next = S_SCAN;
                    if (wy_reg == CELL_LAST) begin
                        wy_next = '0;
                        wx_next = wx_reg + GRID_W'(1);
                    end else begin
                        wy_next = wy_reg + GRID_W'(1);
                    end
                end
            end
            S_NB_RD, S_NB_WR: begin
                raddr = {nx[GRID_W-1:0], ny[GRID_W-1:0]};
                if (state_reg == S_NB_RD && nb_ok) begin
                    state_next = S_NB_WR;
                end else begin
                    if (state_reg == S_NB_WR && tbl_data_reg > rd_data_reg) begin
                        we    = 1'b1;
                        waddr = {nx[GRID_W-1:0], ny[GRID_W-1:0]};
                        wdata = tbl_data_reg;
                    end
                    // step to next neighbor, or back to the cell scan, or to idle after the last cell
                    if (nb_last) begin
                        if (cell_last) begin
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            state_next = S_SCAN;
                            if (wy_reg == CELL_LAST) begin
                                wy_next = '0;
                                wx_next = wx_reg + GRID_W'(1);
                            end else begin
                                wy_next = wy_reg + GRID_W'(1);
                            end
                        end
                    end else begin
                        state_next = S_NB_RD;
                        if (dy_reg == r_pos) begin
                            dy_next = r_neg;
                            dx_next = dx_reg + (RAD_W+1)'(1);
                        end else begin
                            dy_next = dy_reg + (RAD_W+1)'(1);
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wx_reg       <= wx_next;
        wy_reg       <= wy_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        tax_reg      <= tax_next;
        tay_reg      <= tay_next;
        out_cost_reg <= out_cost_next;
        out_rng_reg  <= out_rng_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            grid_mem[waddr] <= wdata;
        end
        rd_data_reg <= grid_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[{tax_reg, tay_reg}] <= dec_cost;
        end
        tbl_data_reg <= tbl_mem[{adx, ady}];
    end
endmodule

// ===== rtl/costmap_obstacle_inflation.sv =====
// costmap_obstacle_inflation: top level, configuration registers and wiring of
// front queue and back engine; depends on cinf_pkg, cinf_front, cinf_back
//
// channel   dir  signals                    payload
// s_        in   s_tvalid/s_tready/s_tdata  action, x_cell, y_cell
// m_        out  m_tvalid/m_tready/m_tdata  cost, in_range
// cfg_      in   cfg_we/cfg_addr/cfg_wdata  inflation_radius_cells, max_cost
//
// mark writes the grid directly from idle and read passes through S_READ;
// results leave through one output register and a two-entry command queue
// keeps input flowing behind it. clear sweeps all 2**(2*GRID_W) grid words,
// one per cycle. inflate builds a (R+1)^2 decay table one entry at a time,
// then scans each cell and raises in-grid obstacle neighbors to table cost.
// after reset the same clearing sweep runs with s_tready low.
`timescale 1ns / 1ps
module costmap_obstacle_inflation (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] action, [11:2] x_cell, [21:12] y_cell, [23:22] zero
    input  logic [cinf_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [6:0] cost, [7] in_range
    output logic [cinf_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [cinf_pkg::COST_W-1:0]       cfg_wdata
);
    import cinf_pkg::*;

    logic [RAD_W-1:0]  radius_reg;
    logic [COST_W-1:0] max_cost_reg;
    logic [COST_W-1:0] max_cost_sat;
    cinf_cmd_t         cmd;
    logic              cmd_valid;
    logic              init_busy;
    logic              cmd_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= RADIUS_RESET;
            max_cost_reg <= MAX_COST_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_RADIUS:   radius_reg   <= cfg_wdata[RAD_W-1:0];
                CFG_MAX_COST: max_cost_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign max_cost_sat = (max_cost_reg > OBSTACLE_COST) ? OBSTACLE_COST : max_cost_reg;

    cinf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .init_busy (init_busy),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    cinf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .init_busy (init_busy),
        .radius    (radius_reg),
        .max_cost  (max_cost_sat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
